>>> rtl/core/bgwg_pkg.sv
// Shared types and constants of the biped gait waveform generator.
// No dependencies; every other file of the block imports this package.
package bgwg_pkg;

  // Field widths fixed by the interface.
  localparam int SINE_W     = 15;   // Q0.15 sine magnitude
  localparam int AMP_W      = 16;   // amplitudes, offsets and turn value
  localparam int STEP_W     = 14;   // phase advance per tick
  localparam int SH_W       = 17;   // stand height
  localparam int LEN_W      = 19;   // leg length outputs
  localparam int SWAY_W     = 17;   // sway outputs
  localparam int LIFT_W     = 18;   // lift outputs
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 128;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIFT_AMP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIFT_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_AMP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWAY_AMP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_AMP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STAND_HT    = 3'd6;

  // Register reset values.
  localparam logic [STEP_W-1:0] RST_PHASE_STEP  = 14'd1304;
  localparam logic [AMP_W-1:0]  RST_LIFT_AMP    = 16'd6400;
  localparam logic [AMP_W-1:0]  RST_LIFT_OFFSET = 16'd6400;
  localparam logic [AMP_W-1:0]  RST_STRIDE_AMP  = 16'd10240;
  localparam logic [AMP_W-1:0]  RST_SWAY_AMP    = 16'd1792;
  localparam logic [AMP_W-1:0]  RST_TURN_AMP    = 16'd512;
  localparam logic [SH_W-1:0]   RST_STAND_HT    = 17'd99840;

  // Stride window: 3333*H <= 10000*h <= 6666*H, pulse angle is the excess / 3333.
  localparam int WIN_MUL = 10000;
  localparam int WIN_DIV = 3333;
  // 10*|lift term| < 256 is the same as |lift term| <= 25.
  localparam logic [AMP_W-1:0] STOP_LIFT_MAX = 16'd25;

  typedef struct packed {
    logic              neg;
    logic [SINE_W-1:0] mag;
  } sine_val_t;

  typedef struct packed {
    logic             busy;
    logic             neg;
    logic [AMP_W-1:0] mag;
  } mul_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_A,
    ST_RUN_A,
    ST_FETCH_B,
    ST_LOAD_B,
    ST_RUN_B,
    ST_WRITE
  } gait_state_t;

endpackage

>>> rtl/core/bgwg_sine_lut.sv
// Two-port quarter-wave sine lookup with registered outputs.
// Depends on bgwg_pkg; the table is built at elaboration from a Q30 series.
module bgwg_sine_lut import bgwg_pkg::*; #(
  parameter int PHASE_BITS       = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic [PHASE_BITS-1:0] phase_a,
  input  logic [PHASE_BITS-1:0] phase_b,
  output sine_val_t             sine_a,
  output sine_val_t             sine_b
);

  localparam int QW = PHASE_BITS - 2;
  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = QW + AW;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SERIES_DIV [0:9] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                               64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  typedef logic [SINE_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t               tbl;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] acc;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = HALF_PI_Q30 * 64'(i) / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      acc  = '0;
      for (int k = 0; k < 10; k++) begin
        if (k % 2 == 1) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
        term = ((term * x2) >> 30) / SERIES_DIV[k];
      end
      if (acc < 0) begin
        acc = '0;
      end
      v = ($unsigned(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tbl[i] = SINE_W'(v);
    end
    return tbl;
  endfunction

  localparam rom_t ROM = build_rom();

  // Fold a phase into the first quadrant: returns {negate, table address}.
  function automatic logic [AW:0] fold(input logic [PHASE_BITS-1:0] p);
    logic [1:0]    q;
    logic [PW-1:0] prod;
    logic [AW-1:0] idx;
    logic [AW-1:0] addr;
    q    = p[PHASE_BITS-1:PHASE_BITS-2];
    prod = PW'(p[QW-1:0]) * PW'(SINE_TABLE_DEPTH);
    idx  = prod[PW-1:QW];
    addr = q[0] ? (AW'(SINE_TABLE_DEPTH) - idx) : idx;
    return {q[1], addr};
  endfunction

  logic [AW:0] fold_a;
  logic [AW:0] fold_b;
  sine_val_t   sine_a_r;
  sine_val_t   sine_b_r;

  assign fold_a = fold(phase_a);
  assign fold_b = fold(phase_b);

  always_ff @(posedge clk) begin
    sine_a_r.neg <= fold_a[AW];
    sine_a_r.mag <= ROM[fold_a[AW-1:0]];
    sine_b_r.neg <= fold_b[AW];
    sine_b_r.mag <= ROM[fold_b[AW-1:0]];
  end

  assign sine_a = sine_a_r;
  assign sine_b = sine_b_r;

endmodule

>>> rtl/core/bgwg_ser_mul.sv
// Bit-serial amplitude times sine multiplier, one multiplier bit per cycle.
// Depends on bgwg_pkg; result is round(amp*|sin|/32768) with the sine's sign.
module bgwg_ser_mul import bgwg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AMP_W-1:0] amp,
  input  sine_val_t        sine,
  output mul_out_t         res
);

  localparam int CNT_W = $clog2(SINE_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SINE_W - 1);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [AMP_W-1:0]  amp_r;
  logic              neg_r;
  logic [AMP_W-1:0]  hi_r;
  logic [SINE_W-1:0] lo_r;
  logic [AMP_W-1:0]  addend;
  logic [AMP_W:0]    sum;

  assign addend = lo_r[0] ? amp_r : '0;
  assign sum    = {1'b0, hi_r} + {1'b0, addend};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  // The low half holds the unused multiplier bits and collects product bits.
  always_ff @(posedge clk) begin
    if (start) begin
      amp_r <= amp;
      neg_r <= sine.neg;
      hi_r  <= '0;
      lo_r  <= sine.mag;
    end else if (busy_r) begin
      hi_r <= sum[AMP_W:1];
      lo_r <= {sum[0], lo_r[SINE_W-1:1]};
    end
  end

  assign res.busy = busy_r;
  assign res.neg  = neg_r;
  assign res.mag  = hi_r + AMP_W'(lo_r[SINE_W-1]);

endmodule

>>> rtl/core/bgwg_win_div.sv
// Bit-serial restoring divider by the constant window width 3333.
// Depends on bgwg_pkg; one quotient bit per cycle, PHASE_BITS+1 bits in all.
module bgwg_win_div import bgwg_pkg::*; #(
  parameter int PHASE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [PHASE_BITS+11:0] num,
  output logic                   busy,
  output logic [PHASE_BITS:0]    quo,
  output logic                   rem_zero
);

  localparam int QW    = PHASE_BITS + 1;
  localparam int REM_W = 12;
  localparam int CNT_W = $clog2(QW);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QW - 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [REM_W-1:0] rem_r;
  logic [QW-1:0]    quo_r;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, quo_r[QW-1]};
  assign ge    = trial >= (REM_W + 1)'(WIN_DIV);
  assign diff  = trial - (REM_W + 1)'(WIN_DIV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  // The top bits of the dividend are below the divisor, so they seed the remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= REM_W'(num[PHASE_BITS+11:QW]);
      quo_r <= num[QW-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quo      = quo_r;
  assign rem_zero = (rem_r == '0);

endmodule

>>> rtl/core/biped_gait_waveform_generator_top.sv
// Top level of the biped gait waveform generator: sequencer, registers, output stage.
// Depends on bgwg_pkg, bgwg_sine_lut, bgwg_ser_mul and bgwg_win_div.
//
// Usage. Each input beat on in_* is one servo tick; in_tdata[0] is stop_request.
// For every tick the block returns one beat on out_* with the lift, sway and leg
// length of both legs and the turn value at the current gait phase, then advances the
// phase by phase_step. A stop request is latched; the tick on which the lift sine
// term falls under 0.1 mm is sent with out_tlast set, and every later tick is
// accepted and dropped until reset.
// Configuration is written on cfg_* (always ready); the user must write it only
// while the block is idle, which the block itself does not enforce. The window
// divider and the two bit-serial multiplier lanes, which take one bit per cycle,
// work out each tick; inside the window the lanes run a second pass for the stride
// and turn terms. The result beat is written into the output register once that
// register is free, and the next tick can be taken in the same cycle in which that
// beat is first presented.
// Reset (rst_n low, synchronous) restores the register defaults, puts the phase at
// half a turn, clears the held turn value and the stop state, and empties the
// output stage. While the receiver stalls, the output register holds its beat and
// the next tick is still worked on; it waits only to be written out.
module biped_gait_waveform_generator_top import bgwg_pkg::*; #(
  parameter int PHASE_BITS       = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Tick input. in_tdata: [0] stop_request, [7:1] zero.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Results. out_tdata: [18:0] right_length, [35:19] right_sway, [53:36] right_lift,
  // [69:54] right_turn, [88:70] left_length, [105:89] left_sway,
  // [123:106] left_lift, [127:124] zero. out_tlast is the last flag.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int PB = PHASE_BITS;
  localparam int NW = PB + 13;   // signed window numerator
  localparam logic [PB-1:0] HALF_TURN = PB'(1) << (PB - 1);
  localparam logic [PB-1:0] SWAY_OFS  = PB'(7) << (PB - 3);
  localparam logic [PB:0]   QUO_HALF  = (PB + 1)'(1) << (PB - 1);

  // Configuration registers.
  logic [STEP_W-1:0] phase_step_r;
  logic [AMP_W-1:0]  lift_amp_r;
  logic [AMP_W-1:0]  lift_offset_r;
  logic [AMP_W-1:0]  stride_amp_r;
  logic [AMP_W-1:0]  sway_amp_r;
  logic [AMP_W-1:0]  turn_amp_r;
  logic [SH_W-1:0]   stand_height_r;

  // Gait state.
  gait_state_t       state_r;
  gait_state_t       state_nxt;
  logic [PB-1:0]     phase_r;
  logic [PB-1:0]     phase_nxt;
  logic [AMP_W-1:0]  held_turn_r;
  logic              stop_latched_r;
  logic              finished_r;

  // Per-tick working registers.
  logic [NW-1:0]     n_r;
  logic [NW-1:0]     n_nxt;
  logic              win_r;
  logic              win_nxt;
  logic [AMP_W-1:0]  lift_mag_r;
  logic              lift_neg_r;
  logic [AMP_W-1:0]  sway_mag_r;
  logic              sway_neg_r;

  // Output stage.
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  logic                  out_last_r;
  logic                  out_last_nxt;

  // Control.
  logic              accept;
  logic              begin_item;
  logic              start_a;
  logic              start_b;
  logic              sel_b;
  logic              engines_idle;
  logic              capture_a;
  logic              write_fire;

  // Datapath links.
  logic [PB-1:0]     lut_phase_a;
  logic [PB-1:0]     lut_phase_b;
  sine_val_t         sine_a;
  sine_val_t         sine_b;
  logic [AMP_W-1:0]  lane0_amp;
  logic [AMP_W-1:0]  lane1_amp;
  mul_out_t          lane0_o;
  mul_out_t          lane1_o;
  logic              div_busy;
  logic [PB:0]       div_quo;
  logic              div_rem_zero;
  logic [PB-1:0]     pulse_angle;

  // Result arithmetic.
  logic              upper;
  logic [AMP_W-1:0]  stride_mag;
  logic [AMP_W-1:0]  turn_new;
  logic [AMP_W-1:0]  turn_out;
  logic [LEN_W-1:0]  right_len;
  logic [LEN_W-1:0]  left_len;
  logic [SWAY_W-1:0] sway_pos;
  logic [SWAY_W-1:0] sway_neg;
  logic [LIFT_W-1:0] lift_plus;
  logic [LIFT_W-1:0] lift_minus;
  logic [PB+STEP_W-1:0] phase_sum;

  //--------------------------------------------------------------------------
  // Configuration port. The user must write only while idle; it is not enforced.
  //--------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= RST_PHASE_STEP;
      lift_amp_r     <= RST_LIFT_AMP;
      lift_offset_r  <= RST_LIFT_OFFSET;
      stride_amp_r   <= RST_STRIDE_AMP;
      sway_amp_r     <= RST_SWAY_AMP;
      turn_amp_r     <= RST_TURN_AMP;
      stand_height_r <= RST_STAND_HT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PHASE_STEP:  phase_step_r   <= cfg_data[STEP_W-1:0];
        REG_LIFT_AMP:    lift_amp_r     <= cfg_data[AMP_W-1:0];
        REG_LIFT_OFFSET: lift_offset_r  <= cfg_data[AMP_W-1:0];
        REG_STRIDE_AMP:  stride_amp_r   <= cfg_data[AMP_W-1:0];
        REG_SWAY_AMP:    sway_amp_r     <= cfg_data[AMP_W-1:0];
        REG_TURN_AMP:    turn_amp_r     <= cfg_data[AMP_W-1:0];
        REG_STAND_HT:    stand_height_r <= cfg_data[SH_W-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Sequencer.
  //--------------------------------------------------------------------------
  assign accept       = in_tvalid && in_tready;
  assign begin_item   = accept && !finished_r;
  assign engines_idle = !lane0_o.busy && !lane1_o.busy && !div_busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (begin_item) state_nxt = ST_LOAD_A;
      ST_LOAD_A:  state_nxt = ST_RUN_A;
      ST_RUN_A:   if (engines_idle) state_nxt = win_nxt ? ST_FETCH_B : ST_WRITE;
      ST_FETCH_B: state_nxt = ST_LOAD_B;
      ST_LOAD_B:  state_nxt = ST_RUN_B;
      ST_RUN_B:   if (engines_idle) state_nxt = ST_WRITE;
      ST_WRITE:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    start_a    = 1'b0;
    start_b    = 1'b0;
    sel_b      = 1'b0;
    capture_a  = 1'b0;
    write_fire = 1'b0;
    case (state_r)
      ST_IDLE:    in_tready  = 1'b1;
      ST_LOAD_A:  start_a    = 1'b1;
      ST_RUN_A:   capture_a  = engines_idle;
      ST_FETCH_B: sel_b      = 1'b1;
      ST_LOAD_B:  start_b    = 1'b1;
      ST_RUN_B:   ;
      ST_WRITE:   write_fire = !out_valid_r || out_tready;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  //--------------------------------------------------------------------------
  // Sine lookup. First pass: gait phase and the sway phase, 7/8 turn ahead.
  // Second pass: the pulse angle and half of it.
  //--------------------------------------------------------------------------
  assign pulse_angle = div_quo[PB-1:0];
  assign lut_phase_a = sel_b ? pulse_angle : phase_r;
  assign lut_phase_b = sel_b ? (pulse_angle >> 1) : (phase_r + SWAY_OFS);

  bgwg_sine_lut #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_lut (
    .clk     (clk),
    .phase_a (lut_phase_a),
    .phase_b (lut_phase_b),
    .sine_a  (sine_a),
    .sine_b  (sine_b)
  );

  // Lane 0 does lift, then stride; lane 1 does sway, then turn.
  assign lane0_amp = start_b ? stride_amp_r : lift_amp_r;
  assign lane1_amp = start_b ? turn_amp_r : sway_amp_r;

  bgwg_ser_mul u_lane0 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_a || start_b),
    .amp   (lane0_amp),
    .sine  (sine_a),
    .res   (lane0_o)
  );

  bgwg_ser_mul u_lane1 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_a || start_b),
    .amp   (lane1_amp),
    .sine  (sine_b),
    .res   (lane1_o)
  );

  //--------------------------------------------------------------------------
  // Stride window. With h the phase within its half turn, the numerator
  // 10000*h - 3333*H is negative before the window; its quotient by 3333 is the
  // pulse angle, and the window closes once that angle passes a half turn.
  // The numerator stays within the signed range, so wrapping arithmetic is exact.
  //--------------------------------------------------------------------------
  assign n_nxt = NW'(phase_r[PB-2:0]) * NW'(WIN_MUL) - (NW'(WIN_DIV) << (PB - 1));

  bgwg_win_div #(
    .PHASE_BITS (PHASE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_a),
    .num      (n_r[NW-2:0]),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem_zero (div_rem_zero)
  );

  assign win_nxt = !n_r[NW-1] &&
                   ((div_quo < QUO_HALF) || ((div_quo == QUO_HALF) && div_rem_zero));

  always_ff @(posedge clk) begin
    if (begin_item) begin
      n_r <= n_nxt;
    end
    if (capture_a) begin
      win_r      <= win_nxt;
      lift_mag_r <= lane0_o.mag;
      lift_neg_r <= lane0_o.neg;
      sway_mag_r <= lane1_o.mag;
      sway_neg_r <= lane1_o.neg;
    end
  end

  //--------------------------------------------------------------------------
  // Result assembly. The stride pulse is taken off the right leg in the first
  // half turn and off the left leg in the second.
  //--------------------------------------------------------------------------
  assign upper      = phase_r[PB-1];
  assign stride_mag = win_r ? lane0_o.mag : '0;
  assign turn_new   = upper ? (turn_amp_r - lane1_o.mag) : lane1_o.mag;
  assign turn_out   = win_r ? turn_new : held_turn_r;

  assign right_len  = LEN_W'(stand_height_r) - (upper ? '0 : LEN_W'(stride_mag));
  assign left_len   = LEN_W'(stand_height_r) - (upper ? LEN_W'(stride_mag) : '0);
  // Sway is minus the scaled shifted sine.
  assign sway_pos   = sway_neg_r ? SWAY_W'(sway_mag_r) : (SWAY_W'(0) - SWAY_W'(sway_mag_r));
  assign sway_neg   = SWAY_W'(0) - sway_pos;
  assign lift_plus  = lift_neg_r ? (LIFT_W'(lift_offset_r) - LIFT_W'(lift_mag_r))
                                 : (LIFT_W'(lift_offset_r) + LIFT_W'(lift_mag_r));
  assign lift_minus = lift_neg_r ? (LIFT_W'(lift_offset_r) + LIFT_W'(lift_mag_r))
                                 : (LIFT_W'(lift_offset_r) - LIFT_W'(lift_mag_r));

  assign out_data_nxt = {4'd0, lift_minus, sway_neg, left_len, turn_out,
                         lift_plus, sway_pos, right_len};
  assign out_last_nxt = stop_latched_r && (lift_mag_r <= STOP_LIFT_MAX);

  assign phase_sum = (PB + STEP_W)'(phase_r) + (PB + STEP_W)'(phase_step_r);
  assign phase_nxt = phase_sum[PB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= HALF_TURN;
      held_turn_r    <= '0;
      stop_latched_r <= 1'b0;
      finished_r     <= 1'b0;
    end else begin
      if (begin_item && in_tdata[0]) begin
        stop_latched_r <= 1'b1;
      end
      if (write_fire) begin
        phase_r     <= phase_nxt;
        held_turn_r <= turn_out;
        if (out_last_nxt) begin
          finished_r <= 1'b1;
        end
      end
    end
  end

  // Output register: holds its beat under backpressure.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (write_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (write_fire) begin
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  //--------------------------------------------------------------------------
  // Assertions.
  //--------------------------------------------------------------------------
  // Once the gait has ended, no tick is ever started again.
  a_finished_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> (state_r == ST_IDLE))
    else $error("gait started a tick after it finished");

  // A beat marked last is always backed by the finished state.
  a_last_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> finished_r)
    else $error("last beat sent without finishing the gait");

  // The serial units are never left running while the sequencer waits for a tick.
  a_engines_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> engines_idle)
    else $error("serial unit busy while sequencer idle");

endmodule
